>>> design/rc6_pkg.sv
// ----------------------------------------------------------------------------
// RC6 package
// Shared constants, controller types and word helpers for the RC6 block.
// ----------------------------------------------------------------------------
package rc6_pkg;

  localparam int RC6_ROUNDS = 20;

  localparam logic [31:0] RC6_P32 = 32'hb7e15163;
  localparam logic [31:0] RC6_Q32 = 32'h9e3779b9;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int KEY_LEN_W   = 6;

  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_0   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_1   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_2   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_3   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LEN = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_DECRYPT = 3'd5;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_16 = 6'd16;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_24 = 6'd24;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_32 = 6'd32;

  localparam logic ACTION_EXPAND = 1'b0;
  localparam logic ACTION_BLOCK  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXP_A,
    ST_EXP_B,
    ST_BLK_0,
    ST_BLK_1,
    ST_BLK_2,
    ST_FINISH
  } rc6_state_t;

  typedef struct packed {
    logic accept;
    logic exp_mix_a;
    logic exp_mix_b;
    logic blk_ph0;
    logic blk_ph1;
    logic blk_ph2;
    logic load_result;
  } rc6_cmd_t;

  typedef struct packed {
    logic key_ok;
    logic exp_last;
    logic blk_last;
  } rc6_stat_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] dbl;
    dbl = {x, x} << n;
    return dbl[63:32];
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

  // Quadratic term x * (2x + 1), low 32 bits.
  function automatic logic [31:0] quad32(input logic [31:0] x);
    logic [31:0] odd;
    odd = {x[30:0], 1'b1};
    return x * odd;
  endfunction

endpackage

>>> design/rc6_block_cipher.sv
// ----------------------------------------------------------------------------
// RC6 block cipher
// RC6-32 with a configurable round count, key expansion and block rounds.
// ----------------------------------------------------------------------------
// One item at a time. A block item takes each round and each whitening step
// through the states ST_BLK_0, ST_BLK_1 and ST_BLK_2 in turn, set by the
// single read port of the round-key memory (two keys per step) and the one
// shared multiplier. A key expansion item passes through ST_EXP_A and
// ST_EXP_B for each mixing step. A rejected key length is answered with
// status 1. The round-key table reads as all zeros after reset until the
// first accepted key expansion; there is no clearing pass. A new item is
// accepted while the previous result still waits at the output.
// ----------------------------------------------------------------------------
module rc6_block_cipher #(
  parameter int ROUNDS = rc6_pkg::RC6_ROUNDS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rc6_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rc6_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           action,
  input  logic [63:0]                    block_low,
  input  logic [63:0]                    block_high,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [63:0]                    result_low,
  output logic [63:0]                    result_high,
  output logic                           status
);
  import rc6_pkg::*;

  rc6_cmd_t  cmd;
  rc6_stat_t stat;

  rc6_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rc6_datapath #(
    .ROUNDS (ROUNDS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .action      (action),
    .block_low   (block_low),
    .block_high  (block_high),
    .cmd         (cmd),
    .stat        (stat),
    .result_low  (result_low),
    .result_high (result_high),
    .status      (status)
  );

endmodule

>>> design/rc6_ctrl.sv
// ----------------------------------------------------------------------------
// RC6 controller
// Sequences key expansion and block rounds and owns the item handshake.
// ----------------------------------------------------------------------------
module rc6_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              action,
  output logic              out_valid,
  input  logic              out_stall,
  input  rc6_pkg::rc6_stat_t stat,
  output rc6_pkg::rc6_cmd_t  cmd
);
  import rc6_pkg::*;

  rc6_state_t state;
  rc6_state_t state_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_stall       = 1'b1;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (action == ACTION_BLOCK) begin
            state_next = ST_BLK_0;
          end else if (stat.key_ok) begin
            state_next = ST_EXP_A;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_EXP_A: begin
        cmd.exp_mix_a = 1'b1;
        state_next    = ST_EXP_B;
      end
      ST_EXP_B: begin
        cmd.exp_mix_b = 1'b1;
        state_next    = stat.exp_last ? ST_FINISH : ST_EXP_A;
      end
      ST_BLK_0: begin
        cmd.blk_ph0 = 1'b1;
        state_next  = ST_BLK_1;
      end
      ST_BLK_1: begin
        cmd.blk_ph1 = 1'b1;
        state_next  = ST_BLK_2;
      end
      ST_BLK_2: begin
        cmd.blk_ph2 = 1'b1;
        state_next  = stat.blk_last ? ST_FINISH : ST_BLK_0;
      end
      ST_FINISH: begin
        // Wait until the output register is free before loading the result.
        if (!out_valid || !out_stall) begin
          cmd.load_result = 1'b1;
          out_valid_next  = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/rc6_datapath.sv
// ----------------------------------------------------------------------------
// RC6 datapath
// Configuration registers, round-key memory, key mixing and round logic.
// ----------------------------------------------------------------------------
module rc6_datapath #(
  parameter int ROUNDS = rc6_pkg::RC6_ROUNDS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rc6_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rc6_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                           action,
  input  logic [63:0]                    block_low,
  input  logic [63:0]                    block_high,
  input  rc6_pkg::rc6_cmd_t              cmd,
  output rc6_pkg::rc6_stat_t             stat,
  output logic [63:0]                    result_low,
  output logic [63:0]                    result_high,
  output logic                           status
);
  import rc6_pkg::*;

  localparam int TW     = 2 * ROUNDS + 4;
  localparam int AW     = $clog2(TW);
  localparam int IW     = AW - 1;
  localparam int MAXM   = (TW > 8) ? TW : 8;
  localparam int MW     = $clog2(MAXM + 1);
  localparam int STEP_W = $clog2(3 * MAXM);

  localparam logic [IW-1:0] IDX_LAST  = IW'(ROUNDS + 1);
  localparam logic [IW-1:0] IDX_ONE   = IW'(1);
  localparam logic [AW-1:0] K_LAST    = AW'(TW - 1);
  localparam logic [MW-1:0] TW_M      = MW'(TW);

  // Configuration registers.
  logic [63:0]          key_reg [4];
  logic [KEY_LEN_W-1:0] key_len;
  logic                 decrypt_cfg;
  logic                 keyed;

  // Round-key memory.
  logic [31:0]   key_mem [TW];
  logic [AW-1:0] raddr;
  logic [31:0]   mem_rdata;
  logic [31:0]   rd_val;

  // Working registers.
  logic [31:0]       wa, wb, wc, wd;
  logic [31:0]       lw [8];
  logic [AW-1:0]     k;
  logic [2:0]        j;
  logic [2:0]        c_m1;
  logic              first_lap;
  logic [31:0]       init_val;
  logic [STEP_W-1:0] step_left;
  logic [IW-1:0]     idx;
  logic              dec;
  logic              blk_item;
  logic              reject;
  logic [31:0]       t_raw, u_raw, s_first;

  // Combinational helpers.
  logic [AW-1:0]     k_next;
  logic [2:0]        j_next;
  logic [31:0]       s_val, a_mix;
  logic [31:0]       ab_sum, b_mix;
  logic [3:0]        key_words;
  logic [MW-1:0]     mix_m;
  logic [STEP_W-1:0] total_m1;
  logic [31:0]       t_rot, u_rot;
  logic [31:0]       enc_a, enc_c, dec_a, dec_c;
  logic              is_pre, is_post;
  logic [31:0]       quad_in, quad_out;

  assign stat.key_ok = (key_len == KEY_LEN_16) || (key_len == KEY_LEN_24) ||
                       (key_len == KEY_LEN_32);
  assign stat.exp_last = (step_left == '0);
  assign stat.blk_last = is_post;

  assign is_pre  = dec ? (idx == IDX_LAST) : (idx == '0);
  assign is_post = dec ? (idx == '0) : (idx == IDX_LAST);

  assign key_words = key_len[5:2];
  assign mix_m     = (TW_M > MW'(key_words)) ? TW_M : MW'(key_words);
  assign total_m1  = STEP_W'({mix_m, 1'b0}) + STEP_W'(mix_m) - STEP_W'(1);

  assign k_next = (k == K_LAST) ? '0 : k + AW'(1);
  assign j_next = (j == c_m1) ? '0 : j + 3'd1;

  // Until the first accepted key expansion the table reads as all zeros.
  assign rd_val = keyed ? mem_rdata : '0;

  assign s_val  = first_lap ? init_val : rd_val;
  assign a_mix  = rotl32(s_val + wa + wb, 5'd3);
  assign ab_sum = wa + wb;
  assign b_mix  = rotl32(lw[j] + ab_sum, ab_sum[4:0]);

  // One multiplier serves both quadratic terms of a round.
  assign quad_in  = cmd.blk_ph0 ? wb : wd;
  assign quad_out = quad32(quad_in);

  assign t_rot = rotl32(t_raw, 5'd5);
  assign u_rot = rotl32(u_raw, 5'd5);
  assign enc_a = rotl32(wa ^ t_rot, u_rot[4:0]) + s_first;
  assign enc_c = rotl32(wc ^ u_rot, t_rot[4:0]) + rd_val;
  assign dec_a = rotr32(wa - s_first, u_rot[4:0]) ^ t_rot;
  assign dec_c = rotr32(wc - rd_val, t_rot[4:0]) ^ u_rot;

  assign raddr = cmd.exp_mix_b ? k_next : AW'({idx, cmd.blk_ph1});

  always_ff @(posedge clk) begin
    if (rst) begin
      key_reg[0]  <= '0;
      key_reg[1]  <= '0;
      key_reg[2]  <= '0;
      key_reg[3]  <= '0;
      key_len     <= KEY_LEN_16;
      decrypt_cfg <= 1'b0;
      keyed       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY_0:   key_reg[0]  <= cfg_data;
          CFG_KEY_1:   key_reg[1]  <= cfg_data;
          CFG_KEY_2:   key_reg[2]  <= cfg_data;
          CFG_KEY_3:   key_reg[3]  <= cfg_data;
          CFG_KEY_LEN: key_len     <= cfg_data[KEY_LEN_W-1:0];
          CFG_DECRYPT: decrypt_cfg <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (cmd.accept && action == ACTION_EXPAND && stat.key_ok) begin
        keyed <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exp_mix_a) begin
      key_mem[k] <= a_mix;
    end
    mem_rdata <= key_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      blk_item <= action;
      reject   <= (action == ACTION_EXPAND) && !stat.key_ok;
      dec      <= decrypt_cfg;
      idx      <= decrypt_cfg ? IDX_LAST : '0;
      if (action == ACTION_BLOCK) begin
        wa <= block_low[31:0];
        wb <= block_low[63:32];
        wc <= block_high[31:0];
        wd <= block_high[63:32];
      end else begin
        wa <= '0;
        wb <= '0;
      end
      k         <= '0;
      j         <= '0;
      c_m1      <= 3'(key_words - 4'd1);
      first_lap <= 1'b1;
      init_val  <= RC6_P32;
      step_left <= total_m1;
      for (int i = 0; i < 8; i++) begin
        lw[i] <= key_reg[i / 2][32 * (i % 2) +: 32];
      end
    end

    if (cmd.exp_mix_a) begin
      wa <= a_mix;
    end

    if (cmd.exp_mix_b) begin
      wb        <= b_mix;
      lw[j]     <= b_mix;
      k         <= k_next;
      j         <= j_next;
      init_val  <= init_val + RC6_Q32;
      step_left <= step_left - STEP_W'(1);
      if (k == K_LAST) begin
        first_lap <= 1'b0;
      end
    end

    if (cmd.blk_ph0) begin
      t_raw <= quad_out;
    end
    if (cmd.blk_ph1) begin
      u_raw   <= quad_out;
      s_first <= rd_val;
    end

    if (cmd.blk_ph2) begin
      idx <= dec ? idx - IW'(1) : idx + IW'(1);
      priority if (!dec && is_pre) begin
        wb <= wb + s_first;
        wd <= wd + rd_val;
      end else if (!dec && is_post) begin
        wa <= wa + s_first;
        wc <= wc + rd_val;
      end else if (!dec) begin
        wa <= wb;
        wb <= enc_c;
        wc <= wd;
        wd <= enc_a;
      end else if (is_pre) begin
        // Undo the last whitening, rotate for the first decryption round.
        wa <= wd;
        wb <= wa - s_first;
        wc <= wb;
        wd <= wc - rd_val;
      end else if (is_post) begin
        wb <= wb - s_first;
        wd <= wd - rd_val;
      end else if (idx == IDX_ONE) begin
        wa <= dec_a;
        wc <= dec_c;
      end else begin
        // Finish this decryption round; rotate words for the following one.
        wa <= wd;
        wb <= dec_a;
        wc <= wb;
        wd <= dec_c;
      end
    end

    if (cmd.load_result) begin
      result_low  <= blk_item ? {wb, wa} : '0;
      result_high <= blk_item ? {wd, wc} : '0;
      status      <= reject;
    end
  end

endmodule

>>> test/tb_rc6_block_cipher.sv
// ----------------------------------------------------------------------------
// RC6 block cipher testbench
// A short table of directed steps, then random phases of key setup, key expansion
// and block items. Every reply is checked against a predictor that keeps its own
// round-key schedule and settings, or a known step's row. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_rc6_block_cipher;
  import rc6_pkg::*;

  localparam int NR             = RC6_ROUNDS;
  localparam int TBL_WORDS      = 2 * NR + 4;
  localparam int BLOCK_ITEMS    = 650;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 500;
  localparam int TAIL_CYCLES    = 300;
  localparam logic [63:0] ONES  = 64'hffff_ffff_ffff_ffff;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic        st;
  } reply_t;

  typedef enum logic [1:0] {DO_CFG, DO_ITEM, DO_KNOWN} step_kind_t;

  // A known step expects zero result words and the status given in its row.
  typedef struct packed {
    step_kind_t             kind;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [63:0]            value;
    logic                   act;
    logic [63:0]            lo;
    logic [63:0]            hi;
    logic                   want_st;
  } step_t;

  localparam int NSTEPS = 32;
  localparam step_t SCRIPT [NSTEPS] = '{
    // The round-key table is all zeros after reset.
    '{DO_ITEM,  CFG_KEY_0,   64'd0,  ACTION_BLOCK,  64'd0, 64'd0, 1'b0},
    '{DO_ITEM,  CFG_KEY_0,   64'd0,  ACTION_BLOCK,  ONES,  ONES,  1'b0},
    '{DO_CFG,   CFG_DECRYPT, 64'd1,  ACTION_BLOCK,  64'd0, 64'd0, 1'b0},
    '{DO_ITEM,  CFG_KEY_0,   64'd0,  ACTION_BLOCK,  64'd0, 64'd0, 1'b0},
    '{DO_ITEM,  CFG_KEY_0,   64'd0,  ACTION_BLOCK,  ONES,  ONES,  1'b0},
    '{DO_CFG,   CFG_DECRYPT, 64'd0,  ACTION_BLOCK,  64'd0, 64'd0, 1'b0},
    // Rejected key lengths leave the table untouched.
    '{DO_CFG,   CFG_KEY_LEN, 64'd0,  ACTION_BLOCK,  64'd0, 64'd0, 1'b0},
    '{DO_KNOWN, CFG_KEY_0,   64'd0,  ACTION_EXPAND, 64'd0, 64'd0, 1'b1},
    '{DO_CFG,   CFG_KEY_LEN, 64'd63, ACTION_BLOCK,  64'd0, 64'd0, 1'b0},
    '{DO_KNOWN, CFG_KEY_0,   64'd0,  ACTION_EXPAND, ONES,  ONES,  1'b1},
    '{DO_CFG,   CFG_KEY_LEN, 64'd17, ACTION_BLOCK,  64'd0, 64'd0, 1'b0},
    '{DO_KNOWN, CFG_KEY_0,   64'd0,  ACTION_EXPAND, 64'd0, 64'd0, 1'b1},
    '{DO_ITEM,  CFG_KEY_0,   64'd0,  ACTION_BLOCK,
      64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b0},
    '{DO_CFG,   CFG_KEY_LEN, 64'd16, ACTION_BLOCK,  64'd0, 64'd0, 1'b0},
    '{DO_KNOWN, CFG_KEY_0,   64'd0,  ACTION_EXPAND, 64'd0, 64'd0, 1'b0},
    '{DO_ITEM,  CFG_KEY_0,   64'd0,  ACTION_BLOCK,  64'd0, 64'd0, 1'b0},
    '{DO_ITEM,  CFG_KEY_0,   64'd0,  ACTION_BLOCK,  ONES,  ONES,  1'b0},
    '{DO_CFG,   CFG_KEY_0,   64'h0f1e_2d3c_4b5a_6978, ACTION_BLOCK, 64'd0, 64'd0, 1'b0},
    '{DO_CFG,   CFG_KEY_1,   64'h8796_a5b4_c3d2_e1f0, ACTION_BLOCK, 64'd0, 64'd0, 1'b0},
    '{DO_CFG,   CFG_KEY_2,   ONES,   ACTION_BLOCK,  64'd0, 64'd0, 1'b0},
    '{DO_CFG,   CFG_KEY_3,   ONES,   ACTION_BLOCK,  64'd0, 64'd0, 1'b0},
    '{DO_CFG,   CFG_KEY_LEN, 64'd24, ACTION_BLOCK,  64'd0, 64'd0, 1'b0},
    '{DO_KNOWN, CFG_KEY_0,   64'd0,  ACTION_EXPAND, 64'd0, 64'd0, 1'b0},
    '{DO_ITEM,  CFG_KEY_0,   64'd0,  ACTION_BLOCK,
      64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b0},
    '{DO_CFG,   CFG_KEY_LEN, 64'd32, ACTION_BLOCK,  64'd0, 64'd0, 1'b0},
    '{DO_KNOWN, CFG_KEY_0,   64'd0,  ACTION_EXPAND, 64'd0, 64'd0, 1'b0},
    '{DO_ITEM,  CFG_KEY_0,   64'd0,  ACTION_BLOCK,
      64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b0},
    '{DO_CFG,   CFG_DECRYPT, 64'd1,  ACTION_BLOCK,  64'd0, 64'd0, 1'b0},
    '{DO_ITEM,  CFG_KEY_0,   64'd0,  ACTION_BLOCK,  64'd0, 64'd0, 1'b0},
    '{DO_ITEM,  CFG_KEY_0,   64'd0,  ACTION_BLOCK,  ONES,  ONES,  1'b0},
    '{DO_ITEM,  CFG_KEY_0,   64'd0,  ACTION_BLOCK,
      64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001, 1'b0},
    '{DO_CFG,   CFG_DECRYPT, 64'd0,  ACTION_BLOCK,  64'd0, 64'd0, 1'b0}
  };

  logic                   clk;
  logic                   rst        = 1'b1;
  logic                   cfg_we     = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = CFG_KEY_0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                   in_valid   = 1'b0;
  logic                   in_stall;
  logic                   action     = ACTION_BLOCK;
  logic [63:0]            block_low  = '0;
  logic [63:0]            block_high = '0;
  logic                   out_valid;
  logic                   out_stall  = 1'b0;
  logic [63:0]            result_low;
  logic [63:0]            result_high;
  logic                   status;

  rc6_block_cipher dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .block_low   (block_low),
    .block_high  (block_high),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_low  (result_low),
    .result_high (result_high),
    .status      (status)
  );

  // Shadow settings and round-key schedule.
  logic [63:0]          key_reg [4];
  logic [KEY_LEN_W-1:0] key_len;
  logic                 decrypt_on;
  logic [31:0]          sched [TBL_WORDS];

  reply_t pending_replies [$];
  reply_t head;
  int     mismatches   = 0;
  int     items_sent   = 0;
  int     replies_seen = 0;
  int     hold_left    = 0;
  logic   hold_done    = 1'b0;
  logic   calm         = 1'b0;
  int     quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] rot_left(input logic [31:0] x, input logic [31:0] n);
    logic [4:0] s;
    s = n[4:0];
    if (s == 5'd0) return x;
    return (x << s) | (x >> (6'd32 - s));
  endfunction

  function automatic logic [31:0] rot_right(input logic [31:0] x, input logic [31:0] n);
    logic [4:0] s;
    s = n[4:0];
    if (s == 5'd0) return x;
    return (x >> s) | (x << (6'd32 - s));
  endfunction

  // Rebuilds the schedule from the key registers; returns 1 on a bad length.
  function automatic logic key_schedule();
    logic [31:0] lw [8];
    logic [31:0] a, b;
    int unsigned nwords, steps, i, k, j;
    if (key_len != KEY_LEN_16 && key_len != KEY_LEN_24 && key_len != KEY_LEN_32)
      return 1'b1;
    nwords = key_len / 4;
    for (i = 0; i < nwords; i++) lw[i] = key_reg[i / 2][32 * (i % 2) +: 32];
    sched[0] = RC6_P32;
    for (i = 1; i < TBL_WORDS; i++) sched[i] = sched[i - 1] + RC6_Q32;
    steps = 3 * ((TBL_WORDS > nwords) ? TBL_WORDS : nwords);
    a = '0;
    b = '0;
    k = 0;
    j = 0;
    for (i = 0; i < steps; i++) begin
      sched[k] = rot_left(sched[k] + a + b, 3);
      a = sched[k];
      lw[j] = rot_left(lw[j] + a + b, a + b);
      b = lw[j];
      k = (k + 1) % TBL_WORDS;
      j = (j + 1) % nwords;
    end
    return 1'b0;
  endfunction

  // Returns {D, C, B, A} of the processed block.
  function automatic logic [127:0] crypt_block(input logic [63:0] lo, input logic [63:0] hi);
    logic [31:0] a, b, c, d, t, u, tmp;
    int r;
    a = lo[31:0];
    b = lo[63:32];
    c = hi[31:0];
    d = hi[63:32];
    if (decrypt_on) begin
      c = c - sched[2 * NR + 3];
      a = a - sched[2 * NR + 2];
      for (r = NR; r >= 1; r--) begin
        tmp = d; d = c; c = b; b = a; a = tmp;
        u = rot_left(d * ((d << 1) + 32'd1), 5);
        t = rot_left(b * ((b << 1) + 32'd1), 5);
        c = rot_right(c - sched[2 * r + 1], t) ^ u;
        a = rot_right(a - sched[2 * r], u) ^ t;
      end
      d = d - sched[1];
      b = b - sched[0];
    end else begin
      b = b + sched[0];
      d = d + sched[1];
      for (r = 1; r <= NR; r++) begin
        t = rot_left(b * ((b << 1) + 32'd1), 5);
        u = rot_left(d * ((d << 1) + 32'd1), 5);
        a = rot_left(a ^ t, u) + sched[2 * r];
        c = rot_left(c ^ u, t) + sched[2 * r + 1];
        tmp = a; a = b; b = c; c = d; d = tmp;
      end
      a = a + sched[2 * NR + 2];
      c = c + sched[2 * NR + 3];
    end
    return {d, c, b, a};
  endfunction

  function automatic reply_t rc6_transform(input logic act, input logic [63:0] lo,
                                           input logic [63:0] hi);
    reply_t r;
    logic [127:0] words;
    if (act == ACTION_EXPAND) begin
      r.lo = '0;
      r.hi = '0;
      r.st = key_schedule();
    end else begin
      words = crypt_block(lo, hi);
      r.lo = words[63:0];
      r.hi = words[127:64];
      r.st = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 64'd0;
      1:       return ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch: %s got %h expected %h", what, got, want);
    mismatches++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_KEY_0:   key_reg[0] = val;
      CFG_KEY_1:   key_reg[1] = val;
      CFG_KEY_2:   key_reg[2] = val;
      CFG_KEY_3:   key_reg[3] = val;
      CFG_KEY_LEN: key_len = val[KEY_LEN_W-1:0];
      CFG_DECRYPT: decrypt_on = val[0];
      default: ;
    endcase
  endtask

  // Offers one item; a known item gets zero result words and the given status.
  task automatic offer(input logic act, input logic [63:0] lo, input logic [63:0] hi,
                       input logic known, input logic known_st);
    reply_t want;
    cfg_we <= 1'b0;
    while (!calm && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    want = rc6_transform(act, lo, hi);
    if (known) want = '{lo: 64'd0, hi: 64'd0, st: known_st};
    pending_replies.push_back(want);
    in_valid   <= 1'b1;
    action     <= act;
    block_low  <= lo;
    block_high <= hi;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Stops offering and waits until every expected reply has been checked.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Reply checker and receiver stall control.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        replies_seen++;
        if (pending_replies.size() == 0) begin
          flag_mismatch("reply with nothing pending, result_low", result_low, 64'd0);
        end else begin
          head = pending_replies.pop_front();
          if (result_low !== head.lo) flag_mismatch("result_low", result_low, head.lo);
          if (result_high !== head.hi) flag_mismatch("result_high", result_high, head.hi);
          if (status !== head.st) flag_mismatch("status", 64'(status), 64'(head.st));
        end
      end
      // One long hold-off while the sender keeps offering, so the block fills up.
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && replies_seen >= 40 && in_valid) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 21);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int s, phase, nblk, n;
    logic [KEY_LEN_W-1:0] len;
    for (n = 0; n < 4; n++) key_reg[n] = '0;
    key_len    = KEY_LEN_16;
    decrypt_on = 1'b0;
    for (n = 0; n < TBL_WORDS; n++) sched[n] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (s = 0; s < NSTEPS; s++) begin
      if (SCRIPT[s].kind == DO_CFG) begin
        if (s == 0 || SCRIPT[s - 1].kind != DO_CFG) drain();
        write_reg(SCRIPT[s].reg_idx, SCRIPT[s].value);
      end else begin
        offer(SCRIPT[s].act, SCRIPT[s].lo, SCRIPT[s].hi, SCRIPT[s].kind == DO_KNOWN,
              SCRIPT[s].want_st);
      end
    end

    phase = 0;
    while (items_sent < BLOCK_ITEMS) begin
      drain();
      calm = (phase >= 5 && phase < 9);
      if (phase % 5 == 4) begin
        // Same schedule, other direction.
        write_reg(CFG_DECRYPT, 64'(!decrypt_on));
      end else begin
        write_reg(CFG_KEY_0, pick_word());
        write_reg(CFG_KEY_1, pick_word());
        write_reg(CFG_KEY_2, pick_word());
        write_reg(CFG_KEY_3, pick_word());
        case ($urandom_range(0, 7))
          0, 1:    len = KEY_LEN_16;
          2, 3:    len = KEY_LEN_24;
          4, 5:    len = KEY_LEN_32;
          default: len = KEY_LEN_W'($urandom_range(0, 63));
        endcase
        write_reg(CFG_KEY_LEN, 64'(len));
        write_reg(CFG_DECRYPT, 64'($urandom_range(0, 1)));
        offer(ACTION_EXPAND, pick_word(), pick_word(), 1'b0, 1'b0);
      end
      nblk = $urandom_range(6, 30);
      for (n = 0; n < nblk; n++) begin
        if ($urandom_range(0, 24) == 0)
          offer(ACTION_EXPAND, pick_word(), pick_word(), 1'b0, 1'b0);
        else
          offer(ACTION_BLOCK, pick_word(), pick_word(), 1'b0, 1'b0);
      end
      phase++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
